### sv/fde_pkg.sv
// Shared types and constants for the format directive expander.
`timescale 1ns / 1ps
package fde_pkg;

  // Default number of decoded commands held between front and back
  localparam int QUEUE_DEPTH = 4;

  // ASCII codes used by the decoder and the expander
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_B       = 8'h62;
  localparam logic [7:0] CH_C       = 8'h63;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_U       = 8'h75;

  // Work kinds handed to the back end
  typedef enum logic [1:0] {
    OP_CHAR     = 2'd0,  // one character, taken from data
    OP_SIGNED   = 2'd1,  // sign then three decimal digits
    OP_UNSIGNED = 2'd2,  // three decimal digits
    OP_BINARY   = 2'd3   // eight binary digits of data, MSB first
  } fde_op_t;

  // One decoded command
  typedef struct packed {
    fde_op_t    op;
    logic [7:0] data;
    logic       neg;
    logic [1:0] hundreds;
    logic [3:0] tens;
    logic [3:0] ones;
  } fde_cmd_t;

endpackage

### sv/format_directive_expander.sv
// Top level of the format directive expander: front decoder, command queue, character expander.
`timescale 1ns / 1ps
// One format character enters per item; the front decodes it in the accept cycle and
// pushes a command into a QUEUE_DEPTH-entry queue, so items are taken every cycle while
// the queue has room. The back end sends one character per cycle from an output
// register while the receiver is ready: a plain character or c, %, or unknown directive
// makes one character, u makes three, d four and b eight, so the sustained rate is set
// by the back end's one-character output port. An end-of-string or directive-opening '%'
// item makes no characters and pushes no command. last_char marks each item's final character.
module format_directive_expander
  import fde_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] format_char,
  input  logic [7:0] value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       last_char
);

  logic     q_full;
  logic     q_push;
  fde_cmd_t q_cmd;
  logic     q_pop;
  logic     head_valid;
  fde_cmd_t head_cmd;
  logic     pending;

  fde_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .format_char (format_char),
    .value       (value),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (q_cmd),
    .pending     (pending)
  );

  fde_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  fde_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .last_char  (last_char)
  );

  // Never push into a full queue
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("command pushed into full queue");

  // Never pop an empty queue
  assert property (@(posedge clk) disable iff (rst) q_pop |-> head_valid)
    else $error("command popped from empty queue");

  // A lone percent leaves a directive pending
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !pending && format_char == CH_PERCENT) |=> pending)
    else $error("percent did not set pending directive");

  // A popped command leaves its final character in the output register
  assert property (@(posedge clk) disable iff (rst) q_pop |=> (out_valid && last_char))
    else $error("command finished without a final character");

endmodule

### sv/fde_front.sv
// Front end: accepts format characters, tracks the pending directive, decodes commands.
`timescale 1ns / 1ps
module fde_front
  import fde_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] format_char,
  input  logic [7:0] value,
  input  logic       q_full,
  output logic       q_push,
  output fde_cmd_t   q_cmd,
  output logic       pending
);

  logic       accept;
  logic       pending_next;
  logic [7:0] mag;
  logic [6:0] rest;
  logic [14:0] tens_prod;
  logic [3:0] tens_dig;
  logic [6:0] tens_x10;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Classify the item: end of string, directive opener, directive or plain
  always_comb begin
    q_push       = 1'b0;
    pending_next = pending;
    q_cmd.op     = OP_CHAR;
    q_cmd.data   = format_char;
    q_cmd.neg    = 1'b0;
    mag          = value;
    if (accept) begin
      if (format_char == CH_NUL) begin
        pending_next = 1'b0;
      end else if (pending) begin
        pending_next = 1'b0;
        q_push       = 1'b1;
        case (format_char)
          CH_D: begin
            q_cmd.op  = OP_SIGNED;
            q_cmd.neg = value[7];
            if (value[7]) begin
              mag = 8'(~value + 8'd1);
            end
          end
          CH_U: begin
            q_cmd.op = OP_UNSIGNED;
          end
          CH_B: begin
            q_cmd.op   = OP_BINARY;
            q_cmd.data = value;
          end
          CH_C: begin
            q_cmd.data = value;
          end
          CH_PERCENT: begin
            q_cmd.data = CH_PERCENT;
          end
          default: begin
            q_cmd.data = CH_BANG;
          end
        endcase
      end else if (format_char == CH_PERCENT) begin
        pending_next = 1'b1;
      end else begin
        q_push = 1'b1;
      end
    end

    // Decimal digits of the magnitude: compare for hundreds, reciprocal for tens
    if (mag >= 8'd200) begin
      q_cmd.hundreds = 2'd2;
      rest           = 7'(mag - 8'd200);
    end else if (mag >= 8'd100) begin
      q_cmd.hundreds = 2'd1;
      rest           = 7'(mag - 8'd100);
    end else begin
      q_cmd.hundreds = 2'd0;
      rest           = mag[6:0];
    end
    tens_prod   = 15'(rest) * 15'd205;
    tens_dig    = tens_prod[14:11];
    tens_x10    = 7'(tens_dig) * 7'd10;
    q_cmd.tens  = tens_dig;
    q_cmd.ones  = 4'(rest - tens_x10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else begin
      pending <= pending_next;
    end
  end

endmodule

### sv/fde_queue.sv
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
module fde_queue
  import fde_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  fde_cmd_t push_cmd,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output fde_cmd_t head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fde_cmd_t         entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  // Storage is written without reset
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers wrap at the depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### sv/fde_back.sv
// Back end: expands the head command into registered characters, one per cycle if not stalled.
`timescale 1ns / 1ps
module fde_back
  import fde_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  fde_cmd_t   head_cmd,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       last_char
);

  logic [2:0] idx;
  logic [2:0] last_idx;
  logic       is_last;
  logic       load;
  logic [7:0] ch;
  logic [3:0] digit;

  // Character at the current position of the head command
  always_comb begin
    digit    = 4'd0;
    ch       = head_cmd.data;
    last_idx = 3'd0;
    case (head_cmd.op)
      OP_CHAR: begin
        last_idx = 3'd0;
        ch       = head_cmd.data;
      end
      OP_SIGNED: begin
        last_idx = 3'd3;
        case (idx)
          3'd0:    digit = 4'd0;
          3'd1:    digit = 4'(head_cmd.hundreds);
          3'd2:    digit = head_cmd.tens;
          default: digit = head_cmd.ones;
        endcase
        if (idx == 3'd0) begin
          ch = head_cmd.neg ? CH_MINUS : CH_SPACE;
        end else begin
          ch = CH_ZERO + 8'(digit);
        end
      end
      OP_UNSIGNED: begin
        last_idx = 3'd2;
        case (idx)
          3'd0:    digit = 4'(head_cmd.hundreds);
          3'd1:    digit = head_cmd.tens;
          default: digit = head_cmd.ones;
        endcase
        ch = CH_ZERO + 8'(digit);
      end
      OP_BINARY: begin
        last_idx = 3'd7;
        ch       = head_cmd.data[~idx] ? CH_ONE : CH_ZERO;
      end
      default: begin
        last_idx = 3'd0;
      end
    endcase
  end

  assign is_last = (idx == last_idx);
  assign load    = head_valid && (!out_valid || out_ready);
  assign pop     = load && is_last;

  // Output register and position counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= is_last ? 3'd0 : idx + 3'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char  <= ch;
      last_char <= is_last;
    end
  end

endmodule

### verif/tb_format_directive_expander.sv
// Self-checking testbench for the format directive expander.
`timescale 1ns / 1ps
module tb_format_directive_expander;
  import fde_pkg::*;

  localparam int CLK_HALF   = 5;
  localparam int MAX_CYCLES = 300000;
  localparam int DRAIN_WAIT = 20;

  // One emitted character as predicted
  typedef struct {
    logic [7:0] ch;
    logic       last;
  } exp_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] format_char = CH_NUL;
  logic [7:0] value = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       last_char;

  // Predictor state and the characters still owed by the block
  logic      pending_directive;
  exp_char_t expected_chars[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;

  // Idling controls: gap_mode 0 = back to back, 1 = random gaps;
  // stall_mode 0 = always ready, 1 = occasional stalls, 2 = heavy stalls
  int gap_mode = 1;
  int stall_mode = 1;
  int stall_left = 0;

  format_directive_expander DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .format_char(format_char),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .last_char  (last_char)
  );

  initial begin
    forever begin
      #CLK_HALF clk = ~clk;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Work out the characters one format item produces and queue them
  function automatic void expand_item(input logic [7:0] fc, input logic [7:0] val);
    logic [7:0] chars[$];
    logic [7:0] mag;
    exp_char_t  e;
    chars = {};
    mag = val;
    if (fc == CH_NUL) begin
      pending_directive = 1'b0;
    end else if (pending_directive) begin
      pending_directive = 1'b0;
      case (fc)
        CH_D, CH_U: begin
          if (fc == CH_D) begin
            if (val[7]) begin
              chars.push_back(CH_MINUS);
              mag = 8'(-val);
            end else begin
              chars.push_back(CH_SPACE);
            end
          end
          chars.push_back(8'(CH_ZERO + mag / 100));
          chars.push_back(8'(CH_ZERO + (mag % 100) / 10));
          chars.push_back(8'(CH_ZERO + mag % 10));
        end
        CH_B: begin
          for (int i = 7; i >= 0; i--) begin
            chars.push_back(val[i] ? CH_ONE : CH_ZERO);
          end
        end
        CH_C:       chars.push_back(val);
        CH_PERCENT: chars.push_back(CH_PERCENT);
        default:    chars.push_back(CH_BANG);
      endcase
    end else if (fc == CH_PERCENT) begin
      pending_directive = 1'b1;
    end else begin
      chars.push_back(fc);
    end
    foreach (chars[i]) begin
      e.ch = chars[i];
      e.last = (i == chars.size() - 1);
      expected_chars.push_back(e);
    end
  endfunction

  // Idle gap length: mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gap_mode == 0 || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Send one item, record its prediction on acceptance, then maybe idle
  task automatic send_item(input logic [7:0] fc, input logic [7:0] val);
    int gap;
    in_valid <= 1'b1;
    format_char <= fc;
    value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expand_item(fc, val);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (stall_mode == 1 && $urandom_range(0, 99) < 20) begin
        stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end else if (stall_mode == 2 && $urandom_range(0, 99) < 50) begin
        stall_left <= $urandom_range(1, 12);
      end
    end
  end

  // Compare each emitted character with the oldest prediction
  always @(posedge clk) begin
    exp_char_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) begin
          $display("unexpected char: out_char=%h last_char=%b", out_char, last_char);
        end
      end else begin
        e = expected_chars.pop_front();
        if (out_char !== e.ch || last_char !== e.last) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) begin
            $display("char mismatch: expected %h/%b, got %h/%b",
                     e.ch, e.last, out_char, last_char);
          end
        end
      end
    end
  end

  // Random directive character, sometimes not a known one
  function automatic logic [7:0] pick_directive();
    case ($urandom_range(0, 5))
      0: return CH_D;
      1: return CH_U;
      2: return CH_B;
      3: return CH_C;
      4: return CH_PERCENT;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'h80;
      2: return 8'hFF;
      3: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly well-formed directives and text, plus end markers and stray percents
  task automatic run_random_items(input int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        send_item(CH_PERCENT, 8'($urandom_range(0, 255)));
        send_item(pick_directive(), pick_value());
        n++;
      end else if (r < 85) begin
        send_item(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
      end else if (r < 95) begin
        send_item(CH_NUL, 8'($urandom_range(0, 255)));
      end else begin
        send_item(CH_PERCENT, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Field extremes, every directive and each corner case
  task automatic test_directed();
    send_item(8'h01, 8'hFF);
    send_item(8'hFF, 8'h00);
    send_item("A", 8'h5A);
    send_item(CH_PERCENT, 8'h00);
    send_item(CH_D, 8'h80);  // most negative value
    send_item(CH_PERCENT, 8'h00);
    send_item(CH_D, 8'hFF);
    send_item(CH_PERCENT, 8'h00);
    send_item(CH_D, 8'h7F);
    send_item(CH_PERCENT, 8'h00);
    send_item(CH_D, 8'h00);
    send_item(CH_PERCENT, 8'h00);
    send_item(CH_U, 8'hFF);
    send_item(CH_PERCENT, 8'h00);
    send_item(CH_B, 8'hA5);
    send_item(CH_PERCENT, 8'h00);
    send_item(CH_C, 8'h00);
    send_item(CH_PERCENT, 8'h00);
    send_item(CH_PERCENT, 8'h33);  // percent as directive
    send_item(CH_PERCENT, 8'h00);
    send_item("z", 8'h12);  // unknown directive
    send_item(CH_PERCENT, 8'h00);
    send_item(CH_NUL, 8'h00);  // end of string clears the pending directive
    send_item(CH_D, 8'h99);
    send_item(CH_NUL, 8'hFF);
  endtask

  task automatic test_random_mixed();
    gap_mode = 1;
    stall_mode = 1;
    run_random_items(42);
  endtask

  task automatic test_random_back_to_back();
    gap_mode = 0;
    stall_mode = 0;
    run_random_items(42);
  endtask

  task automatic test_random_backpressure();
    gap_mode = 0;
    stall_mode = 2;
    run_random_items(42);
  endtask

  initial begin
    pending_directive = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_mixed();
    test_random_back_to_back();
    test_random_backpressure();
    in_valid <= 1'b0;
    stall_mode = 1;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
